[hdl/spi_master_byte_shifter_macros.svh]
// ----------------------------------------------------------------------------
// SPI master byte shifter - assertion macros
// Concurrent checks written once; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SPI_MASTER_BYTE_SHIFTER_MACROS_SVH
`define SPI_MASTER_BYTE_SHIFTER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define SMBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SMBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SMBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/smbs_pkg.sv]
// ----------------------------------------------------------------------------
// SPI master byte shifter - package
// Shared types, codes and widths.
// ----------------------------------------------------------------------------
package smbs_pkg;

    localparam int BYTE_W     = 8;
    localparam int BITCNT_W   = 3;
    localparam int WAIT_W     = 7;
    localparam int DIVLOG_W   = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_TICK  = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPI_MODE    = 2'd0,
        REG_LSB_FIRST   = 2'd1,
        REG_DIVIDER_LOG = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [MODE_W-1:0]   spi_mode;
        logic                lsb_first;
        logic [DIVLOG_W-1:0] divider_log;
    } t_cfg;

    typedef struct packed {
        logic wr;
        logic cpol;
    } t_mode_wr;

    typedef struct packed {
        logic              sck_level;
        logic              mosi_level;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
    } t_result;

endpackage

[hdl/smbs_in_if.sv]
// ----------------------------------------------------------------------------
// SPI master byte shifter - input item channel
// Valid/ready channel carrying one start or tick item per transfer.
// ----------------------------------------------------------------------------
interface smbs_in_if;
    import smbs_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [BYTE_W-1:0] tx_byte;
    logic              miso_level;

    modport source (output valid, output func, output tx_byte, output miso_level,
                    input ready);
    modport sink   (input valid, input func, input tx_byte, input miso_level,
                    output ready);
endinterface

[hdl/smbs_out_if.sv]
// ----------------------------------------------------------------------------
// SPI master byte shifter - result channel
// Valid/ready channel carrying pin levels and status per transfer.
// ----------------------------------------------------------------------------
interface smbs_out_if;
    import smbs_pkg::*;

    logic              valid;
    logic              ready;
    logic              sck_level;
    logic              mosi_level;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output sck_level, output mosi_level,
                    output busy_res, output done_res, output rx_byte, input ready);
    modport sink   (input valid, input sck_level, input mosi_level,
                    input busy_res, input done_res, input rx_byte, output ready);
endinterface

[hdl/smbs_cfg_if.sv]
// ----------------------------------------------------------------------------
// SPI master byte shifter - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface smbs_cfg_if;
    import smbs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/smbs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// SPI master byte shifter - configuration registers
// Mode, bit order and divider registers; flags writes of the mode register.
// ----------------------------------------------------------------------------
module smbs_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    smbs_cfg_if.sink          i_cfg,
    output smbs_pkg::t_cfg    o_cfg,
    output smbs_pkg::t_mode_wr o_mode_wr
);
    import smbs_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign i_cfg.ready = 1'b1;
    assign wr_en       = i_cfg.valid && i_cfg.ready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (t_reg_idx'(i_cfg.index))
                REG_SPI_MODE:    n_cfg.spi_mode    = i_cfg.data[MODE_W-1:0];
                REG_LSB_FIRST:   n_cfg.lsb_first   = i_cfg.data[0];
                REG_DIVIDER_LOG: n_cfg.divider_log = i_cfg.data[DIVLOG_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spi_mode    <= '0;
            r_cfg.lsb_first   <= 1'b0;
            r_cfg.divider_log <= DIVLOG_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg          = r_cfg;
    assign o_mode_wr.wr   = wr_en && (t_reg_idx'(i_cfg.index) == REG_SPI_MODE);
    assign o_mode_wr.cpol = i_cfg.data[1];
endmodule

[hdl/smbs_step.sv]
// ----------------------------------------------------------------------------
// SPI master byte shifter - bit sequencer
// Divider, edge sequencing and shift registers, advanced once per item.
// ----------------------------------------------------------------------------
`include "spi_master_byte_shifter_macros.svh"

module smbs_step (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  smbs_pkg::t_cfg             i_cfg,
    input  smbs_pkg::t_mode_wr         i_mode_wr,
    input  logic                       i_accept,
    input  logic                       i_func,
    input  logic [smbs_pkg::BYTE_W-1:0] i_tx_byte,
    input  logic                       i_miso_level,
    output smbs_pkg::t_result          o_result
);
    import smbs_pkg::*;

    logic [BYTE_W-1:0]   r_tx,   n_tx;
    logic [BYTE_W-1:0]   r_rx,   n_rx;
    logic [BITCNT_W-1:0] r_bit,  n_bit;
    logic                r_phase, n_phase;
    logic [WAIT_W-1:0]   r_wait, n_wait;
    logic                r_sck,  n_sck;
    logic                r_mosi, n_mosi;
    logic                r_active, n_active;
    logic                done;

    logic                cpol;
    logic                cpha;
    logic [DIVLOG_W-1:0] div_k;
    logic [WAIT_W:0]     half;
    logic                wait_end;

    function automatic logic [BYTE_W:0] shift_out(input logic [BYTE_W-1:0] tx,
                                                  input logic lsb);
        logic [BYTE_W:0] res;
        if (lsb) begin
            res = {tx[0], 1'b0, tx[BYTE_W-1:1]};
        end else begin
            res = {tx[BYTE_W-1], tx[BYTE_W-2:0], 1'b0};
        end
        return res;
    endfunction

    function automatic logic [BYTE_W-1:0] shift_in(input logic [BYTE_W-1:0] rx,
                                                   input logic miso,
                                                   input logic lsb);
        logic [BYTE_W-1:0] res;
        if (lsb) begin
            res = {miso, rx[BYTE_W-1:1]};
        end else begin
            res = {rx[BYTE_W-2:0], miso};
        end
        return res;
    endfunction

    assign cpol     = i_cfg.spi_mode[1];
    assign cpha     = i_cfg.spi_mode[0];
    assign div_k    = (i_cfg.divider_log == '0) ? DIVLOG_W'(1) : i_cfg.divider_log;
    assign half     = (WAIT_W+1)'(1) << (div_k - DIVLOG_W'(1));
    assign wait_end = ({1'b0, r_wait} + (WAIT_W+1)'(1)) >= half;

    always_comb begin
        n_tx     = r_tx;
        n_rx     = r_rx;
        n_bit    = r_bit;
        n_phase  = r_phase;
        n_wait   = r_wait;
        n_sck    = r_sck;
        n_mosi   = r_mosi;
        n_active = r_active;
        done     = 1'b0;
        if (i_accept) begin
            if (t_func'(i_func) == FUNC_START) begin
                if (!r_active) begin
                    n_tx     = i_tx_byte;
                    n_rx     = '0;
                    n_bit    = '0;
                    n_phase  = 1'b0;
                    n_wait   = '0;
                    n_active = 1'b1;
                    n_sck    = cpol;
                    if (!cpha) begin
                        {n_mosi, n_tx} = shift_out(i_tx_byte, i_cfg.lsb_first);
                    end
                end
            end else if (r_active) begin
                if (wait_end) begin
                    n_wait = '0;
                    n_sck  = !r_sck;
                    if (!r_phase) begin
                        n_phase = 1'b1;
                        if (cpha) begin
                            {n_mosi, n_tx} = shift_out(r_tx, i_cfg.lsb_first);
                        end else begin
                            n_rx = shift_in(r_rx, i_miso_level, i_cfg.lsb_first);
                        end
                    end else begin
                        n_phase = 1'b0;
                        if (cpha) begin
                            n_rx = shift_in(r_rx, i_miso_level, i_cfg.lsb_first);
                        end
                        if (r_bit == '1) begin
                            n_active = 1'b0;
                            done     = 1'b1;
                            n_bit    = '0;
                            n_sck    = cpol;
                        end else begin
                            n_bit = r_bit + BITCNT_W'(1);
                            if (!cpha) begin
                                {n_mosi, n_tx} = shift_out(r_tx, i_cfg.lsb_first);
                            end
                        end
                    end
                end else begin
                    n_wait = r_wait + WAIT_W'(1);
                end
            end
        end
        // idle SCK follows a new polarity straight away
        if (i_mode_wr.wr && !r_active) begin
            n_sck = i_mode_wr.cpol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx     <= '0;
            r_rx     <= '0;
            r_bit    <= '0;
            r_phase  <= 1'b0;
            r_wait   <= '0;
            r_sck    <= 1'b0;
            r_mosi   <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_tx     <= n_tx;
            r_rx     <= n_rx;
            r_bit    <= n_bit;
            r_phase  <= n_phase;
            r_wait   <= n_wait;
            r_sck    <= n_sck;
            r_mosi   <= n_mosi;
            r_active <= n_active;
        end
    end

    assign o_result.sck_level  = n_sck;
    assign o_result.mosi_level = n_mosi;
    assign o_result.busy_res   = n_active;
    assign o_result.done_res   = done;
    assign o_result.rx_byte    = done ? n_rx : '0;

    `SMBS_ASSERT_IMP(a_done_from_active, i_clk, i_rst_n, done, r_active && r_phase,
                     "done without a transfer in its trailing phase")
    `SMBS_ASSERT_IMP(a_idle_counters, i_clk, i_rst_n, !r_active,
                     (r_bit == '0) && !r_phase, "bit counter not cleared while idle")
    `SMBS_ASSERT_IMP(a_idle_sck_cpol, i_clk, i_rst_n, !r_active, r_sck == cpol,
                     "idle SCK not at polarity level")
endmodule

[hdl/smbs_out_skid.sv]
// ----------------------------------------------------------------------------
// SPI master byte shifter - result buffer
// Output register plus skid entry so a stall does not stall the input side until the skid entry is full.
// ----------------------------------------------------------------------------
`include "spi_master_byte_shifter_macros.svh"

module smbs_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  smbs_pkg::t_result i_data,
    output logic              o_ready,
    smbs_out_if.source        o_result
);
    import smbs_pkg::*;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    pop_ok;

    assign o_ready = !r_skid_valid;
    assign pop_ok  = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop_ok) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
                r_out       <= i_data;
            end
        end else if (i_push) begin
            r_skid       <= i_data;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.sck_level  = r_out.sck_level;
    assign o_result.mosi_level = r_out.mosi_level;
    assign o_result.busy_res   = r_out.busy_res;
    assign o_result.done_res   = r_out.done_res;
    assign o_result.rx_byte    = r_out.rx_byte;

    `SMBS_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
                     "skid entry held with output register empty")
    `SMBS_ASSERT_NXT(a_stall_fills_skid, i_clk, i_rst_n,
                     r_out_valid && !o_result.ready && i_push, r_skid_valid,
                     "result lost on stalled output")
endmodule

[hdl/spi_master_byte_shifter.sv]
// ----------------------------------------------------------------------------
// SPI master byte shifter - top level
// Mode 0 to 3 SPI master, one byte per SPI transfer, driven by tick items.
// ----------------------------------------------------------------------------
// Use: each input transfer on i_item is a start (func 0, tx_byte) or one
// clock tick (func 1, sampled miso_level). Every input transfer gives exactly
// one result transfer on o_result with the SCK and MOSI levels, busy, done
// and, on the completing tick, the received byte.
// i_cfg writes spi_mode (index 0), lsb_first (1) and divider_log (2); it is
// always ready and should be written only while no transfer is running.
// Output: results are registered before they are offered on o_result.
// Throughput: one item per cycle while i_item ready is high; the sequencer
// state updates on each accepted item from its registers, the item and the configuration.
// Stall: a result register and one skid entry sit on the output; i_item
// ready drops only once both hold results, and rises after the next take.
// Reset (synchronous, active low): idle, SCK and MOSI low, mode 0, MSB
// first, divider_log 1; the output buffer is emptied.
// ----------------------------------------------------------------------------
module spi_master_byte_shifter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smbs_in_if.sink    i_item,
    smbs_cfg_if.sink   i_cfg,
    smbs_out_if.source o_result
);
    import smbs_pkg::*;

    t_cfg     cfg;
    t_mode_wr mode_wr;
    t_result  step_res;
    logic     in_ready;
    logic     accept;

    assign i_item.ready = in_ready;
    assign accept       = i_item.valid && in_ready;

    smbs_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_cfg     (cfg),
        .o_mode_wr (mode_wr)
    );

    smbs_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_mode_wr    (mode_wr),
        .i_accept     (accept),
        .i_func       (i_item.func),
        .i_tx_byte    (i_item.tx_byte),
        .i_miso_level (i_item.miso_level),
        .o_result     (step_res)
    );

    smbs_out_skid u_out_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_data   (step_res),
        .o_ready  (in_ready),
        .o_result (o_result)
    );
endmodule

[tb/smbs_shifter_checker.sv]
// ----------------------------------------------------------------------------
// SPI master byte shifter - result checker
// Watches the item, configuration and result channels. Keeps its own copy of
// the SPI sequencer state, predicts the pin levels and status for every item
// transfer, and compares each result transfer in order against them.
// ----------------------------------------------------------------------------
module smbs_shifter_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    smbs_in_if   i_item,
    smbs_cfg_if  i_cfg,
    smbs_out_if  i_result,
    output int   o_fail_count,
    output int   o_pending,
    output logic o_spi_busy
);
    import smbs_pkg::*;

    t_cfg                cfg_q;
    logic [BYTE_W-1:0]   tx_shreg;
    logic [BYTE_W-1:0]   rx_shreg;
    logic [BITCNT_W-1:0] bit_idx;
    logic                trailing_next;
    logic [WAIT_W-1:0]   tick_cnt;
    logic                sck_q;
    logic                mosi_q;
    logic                xfer_active;

    t_result     pending_results[$];
    t_result     got;
    t_result     want;
    logic        done_now;
    int unsigned half;
    int          bad_results = 0;

    function void shift_out();
        if (cfg_q.lsb_first) begin
            mosi_q   = tx_shreg[0];
            tx_shreg = tx_shreg >> 1;
        end else begin
            mosi_q   = tx_shreg[BYTE_W-1];
            tx_shreg = tx_shreg << 1;
        end
    endfunction

    function void shift_in(input logic miso);
        if (cfg_q.lsb_first) begin
            rx_shreg = {miso, rx_shreg[BYTE_W-1:1]};
        end else begin
            rx_shreg = {rx_shreg[BYTE_W-2:0], miso};
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_q         = '{spi_mode: '0, lsb_first: 1'b0, divider_log: 3'd1};
            tx_shreg      = '0;
            rx_shreg      = '0;
            bit_idx       = '0;
            trailing_next = 1'b0;
            tick_cnt      = '0;
            sck_q         = 1'b0;
            mosi_q        = 1'b0;
            xfer_active   = 1'b0;
            pending_results.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got.sck_level  = i_result.sck_level;
                got.mosi_level = i_result.mosi_level;
                got.busy_res   = i_result.busy_res;
                got.done_res   = i_result.done_res;
                got.rx_byte    = i_result.rx_byte;
                if (pending_results.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display(
                            "unexpected result: sck %b mosi %b busy %b done %b rx %h",
                            got.sck_level, got.mosi_level, got.busy_res,
                            got.done_res, got.rx_byte);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display(
                                "mismatch (exp/act): sck %b/%b mosi %b/%b busy %b/%b %s",
                                want.sck_level, got.sck_level,
                                want.mosi_level, got.mosi_level,
                                want.busy_res, got.busy_res,
                                $sformatf("done %b/%b rx %h/%h",
                                          want.done_res, got.done_res,
                                          want.rx_byte, got.rx_byte));
                    end
                end
            end

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_SPI_MODE: begin
                        cfg_q.spi_mode = i_cfg.data[MODE_W-1:0];
                        if (!xfer_active)
                            sck_q = cfg_q.spi_mode[1];
                    end
                    REG_LSB_FIRST:   cfg_q.lsb_first   = i_cfg.data[0];
                    REG_DIVIDER_LOG: cfg_q.divider_log = i_cfg.data[DIVLOG_W-1:0];
                    default: ;
                endcase
            end

            if (i_item.valid && i_item.ready) begin
                done_now = 1'b0;
                if (i_item.func == FUNC_START) begin
                    if (!xfer_active) begin
                        tx_shreg      = i_item.tx_byte;
                        rx_shreg      = '0;
                        bit_idx       = '0;
                        trailing_next = 1'b0;
                        tick_cnt      = '0;
                        xfer_active   = 1'b1;
                        sck_q         = cfg_q.spi_mode[1];
                        if (!cfg_q.spi_mode[0])
                            shift_out();
                    end
                end else if (xfer_active) begin
                    // divider 0 behaves as 1
                    half = 1 << (((cfg_q.divider_log == 0) ? 1 : cfg_q.divider_log) - 1);
                    if (tick_cnt + 1 >= half) begin
                        tick_cnt = '0;
                        sck_q    = ~sck_q;
                        if (!trailing_next) begin
                            trailing_next = 1'b1;
                            if (cfg_q.spi_mode[0])
                                shift_out();
                            else
                                shift_in(i_item.miso_level);
                        end else begin
                            trailing_next = 1'b0;
                            if (cfg_q.spi_mode[0])
                                shift_in(i_item.miso_level);
                            if (bit_idx == 3'd7) begin
                                xfer_active = 1'b0;
                                done_now    = 1'b1;
                                bit_idx     = '0;
                                sck_q       = cfg_q.spi_mode[1];
                            end else begin
                                bit_idx = bit_idx + 1'b1;
                                if (!cfg_q.spi_mode[0])
                                    shift_out();
                            end
                        end
                    end else begin
                        tick_cnt = tick_cnt + 1'b1;
                    end
                end
                want.sck_level  = sck_q;
                want.mosi_level = mosi_q;
                want.busy_res   = xfer_active;
                want.done_res   = done_now;
                want.rx_byte    = done_now ? rx_shreg : '0;
                pending_results.push_back(want);
            end
        end
        o_fail_count <= bad_results;
        o_pending    <= pending_results.size();
        o_spi_busy   <= xfer_active;
    end

endmodule

[tb/tb_spi_master_byte_shifter.sv]
// ----------------------------------------------------------------------------
// SPI master byte shifter - testbench top
// Drives start and tick items through all clock modes, both bit orders and
// a spread of divider settings, with sender gaps and receiver stalls in
// phases, and one long receiver hold-off. The checker beside the block gives
// the verdict.
// ----------------------------------------------------------------------------
module tb_spi_master_byte_shifter;
    import smbs_pkg::*;

    localparam int                   LIMIT_CYCLES = 500000;
    localparam int                   HOLD_CYCLES  = 60;
    localparam int                   PHASES       = 16;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    logic spi_busy;

    int   idle_pct  = 0;
    int   stall_pct = 0;
    bit   hold_req  = 0;
    int   items_sent = 0;
    int   cycles = 0;
    int   div_tab[PHASES] = '{1, 0, 2, 1, 3, 2, 0, 1, 2, 1, 4, 0, 2, 1, 3, 5};

    smbs_in_if  item_ch ();
    smbs_cfg_if cfg_ch ();
    smbs_out_if res_ch ();

    spi_master_byte_shifter uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    smbs_shifter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_cfg        (cfg_ch),
        .i_result     (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_spi_busy   (spi_busy)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic offer_item(input t_func f, input logic [BYTE_W-1:0] tx, input logic miso);
        while ($urandom_range(0, 99) < idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.func       <= f;
        item_ch.tx_byte    <= tx;
        item_ch.miso_level <= miso;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // finish any running byte, then wait for every result to come back
    task automatic drain_to_idle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (spi_busy)
            offer_item(FUNC_TICK, BYTE_W'($urandom), 1'($urandom));
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_tx_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    initial begin
        int unsigned half;
        int          budget;
        int          base;
        int          nticks;
        int          sel;

        i_rst_n            <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.func       <= FUNC_TICK;
        item_ch.tx_byte    <= '0;
        item_ch.miso_level <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_SPI_MODE;
        cfg_ch.data        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: tick while idle, a full byte, a start while busy
        offer_item(FUNC_TICK, 8'h00, 1'b1);
        offer_item(FUNC_START, 8'hA5, 1'b0);
        offer_item(FUNC_START, 8'h3C, 1'b1);
        repeat (16) offer_item(FUNC_TICK, 8'hFF, 1'b1);
        offer_item(FUNC_TICK, 8'h00, 1'b0);
        drain_to_idle();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 5)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                3: begin idle_pct = 71; stall_pct = 71; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            write_reg(REG_SPI_MODE, {1'($urandom), 2'(p % 4)});
            write_reg(REG_LSB_FIRST, {2'($urandom), 1'((p / 4) % 2)});
            write_reg(REG_DIVIDER_LOG, CFG_DATA_W'(div_tab[p]));
            if (p == 3)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            if (p == 5)
                hold_req = 1;

            half   = 1 << (((div_tab[p] == 0) ? 1 : div_tab[p]) - 1);
            budget = (div_tab[p] >= 4) ? 1 : 50;
            base   = items_sent;
            while (items_sent - base < budget) begin
                sel = $urandom_range(0, 99);
                if (sel < 8) begin
                    offer_item(t_func'($urandom_range(0, 1)), BYTE_W'($urandom), 1'($urandom));
                end else begin
                    offer_item(FUNC_START, pick_tx_byte(), 1'($urandom));
                    if (sel < 18)
                        nticks = $urandom_range(1, 16 * half);
                    else
                        nticks = 16 * half + $urandom_range(0, 3);
                    for (int t = 0; t < nticks; t++) begin
                        if ($urandom_range(0, 99) < 4)
                            offer_item(FUNC_START, BYTE_W'($urandom), 1'($urandom));
                        offer_item(FUNC_TICK, BYTE_W'($urandom), 1'($urandom));
                    end
                end
            end
            drain_to_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
